// File: rtl/fixed_width_number_to_ascii_assert.svh
// Assertion macros shared by the checker of the number formatter.
`ifndef FIXED_WIDTH_NUMBER_TO_ASCII_ASSERT_SVH
`define FIXED_WIDTH_NUMBER_TO_ASCII_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define FWNA_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("number formatter check failed");

// Checked on every rising edge, reset included.
`define FWNA_CHECK_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("number formatter reset check failed");

`endif

// File: rtl/fwna_pkg.sv
package fwna_pkg;

	// Format selector codes carried on s_tuser.
	localparam logic [1:0] FMT_UDEC = 2'd0;
	localparam logic [1:0] FMT_SDEC = 2'd1;
	localparam logic [1:0] FMT_HEX  = 2'd2;

	localparam int DEC_DIGITS = 5;
	localparam int HEX_DIGITS = 4;
	localparam int BIN_W      = 32;
	localparam int BCD_W      = 4 * DEC_DIGITS;

	// One number in flight through the conversion pipeline.
	typedef struct packed {
		logic               is_hex;
		logic               is_signed;
		logic               neg;
		logic [2:0]         cnt;
		logic [15:0]        hexv;
		logic [BIN_W-1:0]   bin;
		logic [BCD_W-1:0]   bcd;
	} item_t;

endpackage

// File: rtl/fwna_dabble.sv
// Four register stages of shift-and-add-3 binary to BCD conversion, eight bits
// per stage. Only the five low decimal digits are kept, so the overflow out of
// the top digit drops away and the result is the magnitude modulo 100000.
module fwna_dabble import fwna_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_take,
	output item_t out_item
);

	localparam int STEPS = 8;
	localparam int SR_W  = BCD_W + BIN_W;

	function automatic item_t dabble8(input item_t it);
		logic [SR_W-1:0] sr;
		item_t           res;
		sr = {it.bcd, it.bin};
		for (int s = 0; s < STEPS; s++) begin
			for (int d = 0; d < DEC_DIGITS; d++) begin
				if (sr[BIN_W + 4*d +: 4] >= 4'd5) begin
					sr[BIN_W + 4*d +: 4] = sr[BIN_W + 4*d +: 4] + 4'd3;
				end
			end
			sr = {sr[SR_W-2:0], 1'b0};
		end
		res     = it;
		res.bcd = sr[SR_W-1:BIN_W];
		res.bin = sr[BIN_W-1:0];
		return res;
	endfunction

	logic  valid_s2, valid_s3, valid_s4, valid_s5;
	item_t item_s2, item_s3, item_s4, item_s5;
	logic  en2, en3, en4, en5;

	assign en5      = !valid_s5 || out_take;
	assign en4      = !valid_s4 || en5;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign in_ready = en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en2) valid_s2 <= in_valid;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && in_valid) item_s2 <= dabble8(in_item);
		if (en3 && valid_s2) item_s3 <= dabble8(item_s2);
		if (en4 && valid_s3) item_s4 <= dabble8(item_s3);
		if (en5 && valid_s4) item_s5 <= dabble8(item_s4);
	end

	assign out_valid = valid_s5;
	assign out_item  = item_s5;

endmodule

// File: rtl/fixed_width_number_to_ascii.sv
// A number passes the input stage, the decimal conversion, the layout stage and the output serializer, in that order.
// The character port moves one word per cycle while m_tready is high, so a number takes 1 to 6
// words (its character count); the serializer at the output sets that pace.
// A new number may be taken in every cycle while the pipeline has room.
// Reset: arst_n clears all valid bits and the character position at once; data
// registers are not reset.
module fixed_width_number_to_ascii import fwna_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // digit_count [2:0], value [34:3], zero fill above
	input  logic [1:0]  s_tuser,   // func [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // ascii_char [6:0], zero fill [7]
	output logic        m_tlast
);

	// Characters are held right-aligned in a six-entry list: the units digit
	// sits in the last slot, higher digits to its left, and a sign character
	// just left of the most significant digit. The serializer starts at the
	// first used slot and walks to the end, so the final slot is always last.
	localparam int          MAX_CHARS = 6;
	localparam int          POS_W     = $clog2(MAX_CHARS);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_CHARS - 1);
	localparam logic [6:0]  CH_ZERO   = 7'h30;
	localparam logic [6:0]  CH_A      = 7'h41;
	localparam logic [6:0]  CH_PLUS   = 7'h2B;
	localparam logic [6:0]  CH_MINUS  = 7'h2D;

	function automatic logic [6:0] glyph(input logic [3:0] d);
		if (d < 4'd10) begin
			return CH_ZERO + {3'b000, d};
		end else begin
			return CH_A + {3'b000, d} - 7'd10;
		end
	endfunction

	// Stage 1: decode the format, clamp the digit count and take the magnitude.
	logic       valid_s1;
	item_t      item_s1;
	logic       en1;
	logic       dd_ready;
	logic [2:0] cnt_raw;
	logic [2:0] cnt_min1;
	logic [31:0] value_in;
	item_t      item_dec;

	assign cnt_raw  = s_tdata[2:0];
	assign value_in = s_tdata[34:3];
	assign cnt_min1 = (cnt_raw == 3'd0) ? 3'd1 : cnt_raw;

	always_comb begin
		item_dec           = '0;
		item_dec.is_hex    = (s_tuser == FMT_HEX);
		item_dec.is_signed = (s_tuser == FMT_SDEC);
		item_dec.neg       = item_dec.is_signed && value_in[31];
		if (item_dec.is_hex) begin
			item_dec.cnt = (cnt_min1 > 3'(HEX_DIGITS)) ? 3'(HEX_DIGITS) : cnt_min1;
		end else begin
			item_dec.cnt = (cnt_min1 > 3'(DEC_DIGITS)) ? 3'(DEC_DIGITS) : cnt_min1;
		end
		item_dec.hexv = value_in[15:0];
		item_dec.bin  = item_dec.neg ? (~value_in + 32'd1) : value_in;
		item_dec.bcd  = '0;
	end

	assign en1      = !valid_s1 || dd_ready;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) item_s1 <= item_dec;
	end

	// Stages 2 to 5: decimal conversion.
	logic  dd_valid;
	item_t dd_item;
	logic  en6;

	fwna_dabble u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (dd_ready),
		.in_item   (item_s1),
		.out_valid (dd_valid),
		.out_take  (en6),
		.out_item  (dd_item)
	);

	// Stage 6: lay the characters out in the right-aligned list.
	logic             valid_s6;
	logic [6:0]       chars_s6 [MAX_CHARS];
	logic [POS_W-1:0] start_s6;
	logic [6:0]       chars_d  [MAX_CHARS];
	logic [POS_W-1:0] start_d;
	logic [2:0]       n_chars;
	logic             ser_take;

	always_comb begin
		for (int j = 0; j < MAX_CHARS; j++) begin
			chars_d[j] = CH_ZERO;
			if (dd_item.is_hex) begin
				if ((MAX_CHARS - 1 - j) < HEX_DIGITS) begin
					chars_d[j] = glyph(dd_item.hexv[4*(MAX_CHARS-1-j) +: 4]);
				end
			end else if ((MAX_CHARS - 1 - j) < DEC_DIGITS) begin
				if (dd_item.is_signed && (dd_item.cnt == 3'(MAX_CHARS - 1 - j))) begin
					chars_d[j] = dd_item.neg ? CH_MINUS : CH_PLUS;
				end else begin
					chars_d[j] = glyph(dd_item.bcd[4*(MAX_CHARS-1-j) +: 4]);
				end
			end else if (dd_item.is_signed) begin
				// Only a full five-digit signed number reaches the first slot.
				chars_d[j] = dd_item.neg ? CH_MINUS : CH_PLUS;
			end
		end
		n_chars = dd_item.cnt + {2'b00, dd_item.is_signed};
		start_d = POS_W'(MAX_CHARS) - n_chars;
	end

	assign en6 = !valid_s6 || ser_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en6) begin
			valid_s6 <= dd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en6 && dd_valid) begin
			chars_s6 <= chars_d;
			start_s6 <= start_d;
		end
	end

	// Output serializer: holds one number and shows one character per word.
	logic             ser_valid_q;
	logic [6:0]       chars_q [MAX_CHARS];
	logic [POS_W-1:0] pos_q;
	logic             at_last;

	assign at_last  = (pos_q == LAST_POS);
	assign ser_take = !ser_valid_q || (m_tready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			pos_q       <= '0;
		end else if (ser_take) begin
			ser_valid_q <= valid_s6;
			pos_q       <= start_s6;
		end else if (m_tready) begin
			pos_q <= pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ser_take && valid_s6) chars_q <= chars_s6;
	end

	assign m_tvalid = ser_valid_q;
	assign m_tdata  = {1'b0, chars_q[pos_q]};
	assign m_tlast  = at_last;

endmodule

// File: rtl/fwna_checker.sv
`include "fixed_width_number_to_ascii_assert.svh"

module fwna_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	logic is_digit;
	logic is_hex_letter;
	logic is_sign;

	assign is_digit      = (m_tdata >= CH_ZERO) && (m_tdata <= CH_NINE);
	assign is_hex_letter = (m_tdata >= CH_A) && (m_tdata <= CH_F);
	assign is_sign       = (m_tdata == CH_PLUS) || (m_tdata == CH_MINUS);

	// In the cycle after reset is seen low, nothing is offered.
	`FWNA_CHECK_RST(a_idle_in_reset, !arst_n |=> !m_tvalid)

	// A stalled word stays put.
	`FWNA_CHECK(a_hold_on_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// Every word is a digit, an uppercase hex letter or a sign.
	`FWNA_CHECK(a_char_set, m_tvalid |-> (is_digit || is_hex_letter || is_sign))

	// A sign always has a digit after it.
	`FWNA_CHECK(a_sign_not_last, m_tvalid && is_sign |-> !m_tlast)

endmodule

bind fixed_width_number_to_ascii fwna_checker u_fwna_checker (.*);

// File: verif/tb_fixed_width_number_to_ascii.sv
`timescale 1ns / 1ps

module tb_fixed_width_number_to_ascii;
	import fwna_pkg::*;

	// The format code 3 is not defined by the package; the block treats it as unsigned decimal.
	localparam logic [1:0] FMT_SPARE = 2'd3;

	// ASCII codes that the formatter can emit besides plain digits.
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam logic [6:0] CH_PLUS  = 7'h2B;
	localparam logic [6:0] CH_MINUS = 7'h2D;

	localparam int RANDOM_ITEMS = 385;
	localparam int CALM_FIRST   = 150;
	localparam int CALM_LAST    = 259;
	localparam int DRAIN_AT     = 100;
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DIR_N        = 25;

	// One expected character word on the output side.
	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} ascii_word_t;

	// One row of the directed table. A nonzero typed_len means the expected text is
	// written out in the row itself (last character in the lowest byte); otherwise the
	// row is checked against the formatter model below.
	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  cnt;
		logic [31:0] value;
		logic [2:0]  typed_len;
		logic [47:0] text;
	} number_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // digit_count [2:0], value [34:3], zero fill above
	logic [1:0]  s_tuser = '0;   // func [1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // ascii_char [6:0], zero fill [7]
	logic        m_tlast;

	// While calm is set neither side idles.
	logic        calm = 1'b0;
	int          mismatches = 0;
	int          cycles = 0;
	ascii_word_t pending_chars[$];

	number_row_t directed [0:DIR_N-1] = '{
		'{FMT_UDEC,  3'd5, 32'd0,          3'd5, "00000"},
		'{FMT_UDEC,  3'd5, 32'hFFFF_FFFF,  3'd0, "0"},
		'{FMT_UDEC,  3'd1, 32'd0,          3'd1, "0"},
		// The leading digit is only the low digit of a wider value.
		'{FMT_UDEC,  3'd1, 32'd123,        3'd1, "3"},
		'{FMT_UDEC,  3'd5, 32'd12345,      3'd5, "12345"},
		'{FMT_UDEC,  3'd3, 32'd98765,      3'd3, "765"},
		// A zero digit count prints one digit.
		'{FMT_UDEC,  3'd0, 32'd7,          3'd1, "7"},
		// Counts of six and seven saturate to five decimal digits.
		'{FMT_UDEC,  3'd6, 32'd42,         3'd5, "00042"},
		'{FMT_UDEC,  3'd7, 32'd99999,      3'd5, "99999"},
		// The spare format code behaves as unsigned decimal.
		'{FMT_SPARE, 3'd4, 32'd5678,       3'd4, "5678"},
		'{FMT_SDEC,  3'd5, 32'd0,          3'd6, "+00000"},
		'{FMT_SDEC,  3'd5, 32'h7FFF_FFFF,  3'd0, "0"},
		// The most negative value keeps its minus sign.
		'{FMT_SDEC,  3'd5, 32'h8000_0000,  3'd0, "0"},
		'{FMT_SDEC,  3'd1, 32'hFFFF_FFFF,  3'd2, "-1"},
		'{FMT_SDEC,  3'd3, 32'hFFFF_FF06,  3'd4, "-250"},
		'{FMT_SDEC,  3'd0, 32'd5,          3'd2, "+5"},
		'{FMT_SDEC,  3'd7, 32'd123456,     3'd0, "0"},
		'{FMT_HEX,   3'd4, 32'd0,          3'd4, "0000"},
		'{FMT_HEX,   3'd4, 32'hFFFF_FFFF,  3'd4, "FFFF"},
		// Hex saturates at four digits.
		'{FMT_HEX,   3'd5, 32'hABCD_1234,  3'd4, "1234"},
		'{FMT_HEX,   3'd7, 32'h0000_BEEF,  3'd4, "BEEF"},
		'{FMT_HEX,   3'd1, 32'h0000_002A,  3'd1, "A"},
		'{FMT_HEX,   3'd0, 32'h0000_0009,  3'd1, "9"},
		'{FMT_HEX,   3'd2, 32'h0000_00C3,  3'd0, "0"},
		'{FMT_UDEC,  3'd2, 32'h8000_0000,  3'd0, "0"}
	};

	fixed_width_number_to_ascii uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Works out the characters of one number and queues them as expected words.
	task automatic format_number(input logic [1:0] func, input logic [2:0] cnt,
			input logic [31:0] value);
		int          digits;
		int          p;
		int          q;
		logic [31:0] mag;
		logic [31:0] weight;
		logic [3:0]  d;
		digits = (cnt == 3'd0) ? 1 : int'(cnt);
		if (func == FMT_HEX) begin
			if (digits > HEX_DIGITS)
				digits = HEX_DIGITS;
			for (p = digits; p >= 1; p--) begin
				d = 4'(value >> (4 * (p - 1)));
				pending_chars.push_back('{(d < 4'd10) ? CH_ZERO + 7'(d) : CH_UPPER_A + 7'(d - 4'd10),
					p == 1});
			end
		end else begin
			if (digits > DEC_DIGITS)
				digits = DEC_DIGITS;
			mag = value;
			if (func == FMT_SDEC) begin
				if (value[31]) begin
					pending_chars.push_back('{CH_MINUS, 1'b0});
					mag = -value;
				end else begin
					pending_chars.push_back('{CH_PLUS, 1'b0});
				end
			end
			for (p = digits; p >= 1; p--) begin
				weight = 32'd1;
				for (q = 1; q < p; q++)
					weight = weight * 32'd10;
				d = 4'((mag / weight) % 32'd10);
				pending_chars.push_back('{CH_ZERO + 7'(d), p == 1});
			end
		end
	endtask

	// Offers one number on the input side and waits for the handshake. Called at a
	// rising edge; returns at the edge that took the number, with tvalid still high.
	task automatic send_number(input logic [1:0] func, input logic [2:0] cnt,
			input logic [31:0] value, input logic [2:0] typed_len, input logic [47:0] text);
		int i;
		while (!calm && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {5'd0, value, cnt};
		do
			@(posedge clk);
		while (!s_tready);
		if (typed_len != 3'd0) begin
			for (i = int'(typed_len) - 1; i >= 0; i--)
				pending_chars.push_back('{text[8 * i +: 7], i == 0});
		end else begin
			format_number(func, cnt, value);
		end
	endtask

	// Holds the input side off until every queued character has come out.
	task automatic drain_chars();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_chars.size() != 0);
	endtask

	// The receiver stalls about one cycle in five, except during the calm stretch.
	always @(posedge clk)
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 20);

	// Each character word taken from the block is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected word, actual char %h last %b", $time, m_tdata[6:0],
					m_tlast);
				mismatches++;
			end else begin
				if (m_tdata[6:0] !== pending_chars[0].ch) begin
					$display("%0t: char mismatch, expected %h actual %h", $time,
						pending_chars[0].ch, m_tdata[6:0]);
					mismatches++;
				end
				if (m_tlast !== pending_chars[0].last) begin
					$display("%0t: last mismatch, expected %b actual %b", $time,
						pending_chars[0].last, m_tlast);
					mismatches++;
				end
				void'(pending_chars.pop_front());
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int          n;
		logic [1:0]  func;
		logic [2:0]  cnt;
		logic [31:0] value;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < DIR_N; n++)
			send_number(directed[n].func, directed[n].cnt, directed[n].value,
				directed[n].typed_len, directed[n].text);
		drain_chars();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			calm <= (n >= CALM_FIRST && n <= CALM_LAST);
			// Mostly the three defined formats, now and then the spare code.
			func = ($urandom_range(99) < 8) ? FMT_SPARE : 2'($urandom_range(2));
			// Mostly legal counts, with zero and the oversized counts mixed in.
			if ($urandom_range(99) < 15)
				cnt = 3'($urandom_range(7));
			else
				cnt = 3'($urandom_range(5, 1));
			case ($urandom_range(5))
				0, 1: value = $urandom;
				2: value = $urandom_range(99999);
				3: value = $urandom_range(20);
				4: value = -32'($urandom_range(99999));
				default: begin
					case ($urandom_range(3))
						0: value = 32'h8000_0000;
						1: value = 32'h7FFF_FFFF;
						2: value = 32'hFFFF_FFFF;
						default: value = 32'd0;
					endcase
				end
			endcase
			send_number(func, cnt, value, 3'd0, 48'd0);
			if (n == DRAIN_AT)
				drain_chars();
		end

		drain_chars();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_chars.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
